FILE: rtl/fbbw_pkg.sv
// Package for the framebuffer blend writer: geometry constants, command and
// blend codes, memory request struct and small helper functions.
// No dependencies.
package fbbw_pkg;

    localparam int PAGE_WIDTH = 128;
    localparam int PAGE_COUNT = 8;
    localparam int STORE_SIZE = PAGE_WIDTH * PAGE_COUNT;

    // field widths of the channels
    localparam int CMD_W    = 3;
    localparam int POS_W    = 8;
    localparam int BYTE_W   = 8;
    localparam int BLEND_W  = 2;
    localparam int CURSOR_W = 11;

    // memory index, internal cursor and full address widths
    localparam int MEM_AW = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
    localparam int CUR_W  = $clog2(STORE_SIZE + 1);
    localparam int AF_W   = POS_W + $clog2(PAGE_WIDTH + 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_SET_POS     = 3'd0,
        CMD_WRITE       = 3'd1,
        CMD_FIXED_WRITE = 3'd2,
        CMD_NEXT_LINE   = 3'd3,
        CMD_FILL        = 3'd4,
        CMD_READ        = 3'd5
    } t_cmd;

    typedef enum logic [BLEND_W-1:0] {
        BLEND_REPLACE = 2'd0,
        BLEND_OR      = 2'd1,
        BLEND_AND_NOT = 2'd2,
        BLEND_XOR     = 2'd3
    } t_blend;

    typedef struct packed {
        logic              we;
        logic [MEM_AW-1:0] waddr;
        logic [BYTE_W-1:0] wdata;
        logic              re;
        logic [MEM_AW-1:0] raddr;
    } t_mem_req;

    function automatic logic [BYTE_W-1:0] blend_byte(
        input logic [BYTE_W-1:0] old_byte,
        input logic [BYTE_W-1:0] new_byte,
        input t_blend            mode
    );
        logic [BYTE_W-1:0] res;
        unique case (mode)
            BLEND_REPLACE: res = new_byte;
            BLEND_OR:      res = old_byte | new_byte;
            BLEND_AND_NOT: res = old_byte & ~new_byte;
            BLEND_XOR:     res = old_byte ^ new_byte;
            default:       res = new_byte;
        endcase
        return res;
    endfunction

    // start address of the page that holds addr (addr below STORE_SIZE)
    function automatic logic [CUR_W-1:0] page_base(input logic [CUR_W-1:0] addr);
        logic [CUR_W-1:0] base;
        base = '0;
        for (int k = 1; k < PAGE_COUNT; k++) begin
            if (addr >= CUR_W'(k * PAGE_WIDTH)) begin
                base = CUR_W'(k * PAGE_WIDTH);
            end
        end
        return base;
    endfunction

endpackage

FILE: rtl/fbbw_in_if.sv
// Command channel of the framebuffer blend writer: valid/ready plus payload.
// Depends on fbbw_pkg.
interface fbbw_in_if;
    logic                             valid;
    logic                             ready;
    logic [fbbw_pkg::CMD_W-1:0]       command;
    logic [fbbw_pkg::POS_W-1:0]       page;
    logic [fbbw_pkg::POS_W-1:0]       column;
    logic [fbbw_pkg::BYTE_W-1:0]      pixel_byte;
    logic [fbbw_pkg::BLEND_W-1:0]     blend;
    logic                             from_line_start;

    modport source (
        output valid, command, page, column, pixel_byte, blend, from_line_start,
        input  ready
    );
    modport sink (
        input  valid, command, page, column, pixel_byte, blend, from_line_start,
        output ready
    );
endinterface

FILE: rtl/fbbw_out_if.sv
// Result channel of the framebuffer blend writer: valid/ready plus payload.
// Depends on fbbw_pkg.
interface fbbw_out_if;
    logic                              valid;
    logic                              ready;
    logic [fbbw_pkg::BYTE_W-1:0]       read_data;
    logic [fbbw_pkg::CURSOR_W-1:0]     cursor;
    logic                              done_res;

    modport source (output valid, read_data, cursor, done_res, input ready);
    modport sink   (input  valid, read_data, cursor, done_res, output ready);
endinterface

FILE: rtl/fbbw_store.sv
// Frame byte store: one write port, one read port with registered data.
// Depends on fbbw_pkg.
module fbbw_store (
    input  logic                          i_clk,
    input  fbbw_pkg::t_mem_req            i_req,
    output logic [fbbw_pkg::BYTE_W-1:0]   o_rdata
);
    import fbbw_pkg::*;

    logic [BYTE_W-1:0] r_mem [STORE_SIZE];
    logic [BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/fbbw_ctrl.sv
// Command sequencer: accepts commands, reads the store, blends and writes
// back, runs fill and the clearing sweep, tracks the cursor, holds results.
// Depends on fbbw_pkg, fbbw_in_if, fbbw_out_if.
module fbbw_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    fbbw_in_if.sink                       i_cmd,
    fbbw_out_if.source                    o_res,
    output fbbw_pkg::t_mem_req            o_mem_req,
    input  logic [fbbw_pkg::BYTE_W-1:0]   i_mem_rdata
);
    import fbbw_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FILL
    } t_state;

    t_state              r_state,       n_state;
    t_cmd                r_cmd,         n_cmd;
    logic [BYTE_W-1:0]   r_data,        n_data;
    t_blend              r_blend,       n_blend;
    logic                r_from_start,  n_from_start;
    logic [AF_W-1:0]     r_addr,        n_addr;
    logic                r_addr_ok,     n_addr_ok;
    logic [CUR_W-1:0]    r_cursor,      n_cursor;
    logic [CUR_W-1:0]    r_base,        n_base;
    logic [MEM_AW-1:0]   r_fill_addr,   n_fill_addr;
    logic                r_fill_report, n_fill_report;
    logic                r_out_valid,   n_out_valid;
    logic [BYTE_W-1:0]   r_out_rd,      n_out_rd;
    logic [CURSOR_W-1:0] r_out_cursor,  n_out_cursor;
    logic                r_out_done,    n_out_done;

    logic              accept;
    logic              slot_free;
    logic [AF_W-1:0]   in_addr;
    logic              in_addr_ok;
    logic              cur_ok;
    logic [CUR_W:0]    cur_inc;
    logic [CUR_W:0]    base_next;
    logic [CUR_W:0]    cur_down;
    logic [CUR_W-1:0]  x_cursor;
    logic [CUR_W-1:0]  x_base;
    logic [BYTE_W-1:0] x_rd;
    logic              x_done;
    t_cmd              in_cmd;

    assign i_cmd.ready = (r_state == S_IDLE);
    assign accept      = i_cmd.valid && i_cmd.ready;
    assign slot_free   = !r_out_valid || o_res.ready;
    assign in_cmd      = t_cmd'(i_cmd.command);

    assign in_addr    = AF_W'(i_cmd.page) * AF_W'(PAGE_WIDTH) + AF_W'(i_cmd.column);
    assign in_addr_ok = in_addr < AF_W'(STORE_SIZE);

    assign cur_ok    = r_cursor < CUR_W'(STORE_SIZE);
    assign cur_inc   = {1'b0, r_cursor} + (CUR_W+1)'(1);
    assign base_next = {1'b0, r_base} + (CUR_W+1)'(PAGE_WIDTH);
    assign cur_down  = {1'b0, r_cursor} + (CUR_W+1)'(PAGE_WIDTH);

    // result of the held command, given the byte read when it was accepted
    always_comb begin
        x_cursor       = r_cursor;
        x_base         = r_base;
        x_rd           = '0;
        x_done         = 1'b0;
        o_mem_req      = '0;
        o_mem_req.wdata = blend_byte(i_mem_rdata, r_data, r_blend);
        o_mem_req.waddr = r_cursor[MEM_AW-1:0];

        if (r_state == S_IDLE) begin
            o_mem_req.raddr = (in_cmd == CMD_READ) ? in_addr[MEM_AW-1:0]
                                                    : r_cursor[MEM_AW-1:0];
            case (in_cmd)
                CMD_WRITE, CMD_FIXED_WRITE: o_mem_req.re = accept && cur_ok;
                CMD_READ:                   o_mem_req.re = accept && in_addr_ok;
                default:                    o_mem_req.re = 1'b0;
            endcase
        end else if (r_state == S_FILL) begin
            o_mem_req.we    = 1'b1;
            o_mem_req.waddr = r_fill_addr;
            o_mem_req.wdata = r_data;
        end else begin
            case (r_cmd)
                CMD_SET_POS: begin
                    if (r_addr_ok) begin
                        x_cursor = r_addr[CUR_W-1:0];
                        x_base   = page_base(r_addr[CUR_W-1:0]);
                        x_done   = 1'b1;
                    end
                end
                CMD_WRITE, CMD_FIXED_WRITE: begin
                    // fixed-line write drops on the last column of a page
                    if (cur_ok && (r_cmd == CMD_WRITE || cur_inc != base_next)) begin
                        o_mem_req.we = slot_free;
                        x_cursor     = cur_inc[CUR_W-1:0];
                        if (cur_inc == base_next) begin
                            x_base = base_next[CUR_W-1:0];
                        end
                        x_done = 1'b1;
                    end
                end
                CMD_NEXT_LINE: begin
                    if (r_from_start) begin
                        if (base_next < (CUR_W+1)'(STORE_SIZE)) begin
                            x_cursor = base_next[CUR_W-1:0];
                            x_base   = base_next[CUR_W-1:0];
                            x_done   = 1'b1;
                        end
                    end else if (cur_down < (CUR_W+1)'(STORE_SIZE)) begin
                        x_cursor = cur_down[CUR_W-1:0];
                        x_base   = base_next[CUR_W-1:0];
                        x_done   = 1'b1;
                    end
                end
                CMD_FILL: x_done = 1'b1;
                CMD_READ: begin
                    if (r_addr_ok) begin
                        x_rd   = i_mem_rdata;
                        x_done = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state       = r_state;
        n_cmd         = r_cmd;
        n_data        = r_data;
        n_blend       = r_blend;
        n_from_start  = r_from_start;
        n_addr        = r_addr;
        n_addr_ok     = r_addr_ok;
        n_cursor      = r_cursor;
        n_base        = r_base;
        n_fill_addr   = r_fill_addr;
        n_fill_report = r_fill_report;
        n_out_valid   = r_out_valid && !o_res.ready;
        n_out_rd      = r_out_rd;
        n_out_cursor  = r_out_cursor;
        n_out_done    = r_out_done;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cmd         = in_cmd;
                    n_data        = i_cmd.pixel_byte;
                    n_blend       = t_blend'(i_cmd.blend);
                    n_from_start  = i_cmd.from_line_start;
                    n_addr        = in_addr;
                    n_addr_ok     = in_addr_ok;
                    n_fill_addr   = '0;
                    n_fill_report = 1'b1;
                    n_state       = (in_cmd == CMD_FILL) ? S_FILL : S_EXEC;
                end
            end
            S_FILL: begin
                n_fill_addr = r_fill_addr + MEM_AW'(1);
                if (r_fill_addr == MEM_AW'(STORE_SIZE - 1)) begin
                    n_state = r_fill_report ? S_EXEC : S_IDLE;
                end
            end
            S_EXEC: begin
                // hold until the output register can take the result
                if (slot_free) begin
                    n_cursor     = x_cursor;
                    n_base       = x_base;
                    n_out_valid  = 1'b1;
                    n_out_rd     = x_rd;
                    n_out_cursor = CURSOR_W'(x_cursor);
                    n_out_done   = x_done;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            // clearing sweep after reset writes zero over the whole store
            r_state       <= S_FILL;
            r_fill_addr   <= '0;
            r_fill_report <= 1'b0;
            r_data        <= '0;
            r_cursor      <= '0;
            r_base        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_fill_addr   <= n_fill_addr;
            r_fill_report <= n_fill_report;
            r_data        <= n_data;
            r_cursor      <= n_cursor;
            r_base        <= n_base;
            r_out_valid   <= n_out_valid;
        end
        r_cmd        <= n_cmd;
        r_blend      <= n_blend;
        r_from_start <= n_from_start;
        r_addr       <= n_addr;
        r_addr_ok    <= n_addr_ok;
        r_out_rd     <= n_out_rd;
        r_out_cursor <= n_out_cursor;
        r_out_done   <= n_out_done;
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.read_data = r_out_rd;
    assign o_res.cursor    = r_out_cursor;
    assign o_res.done_res  = r_out_done;

endmodule

FILE: rtl/framebuffer_blend_writer_top.sv
// Page-addressed monochrome framebuffer with a write cursor and blended
// byte writes. Write, fixed-line write and read fetch a byte from the store
// in the accept cycle; for these and for set position and next line the
// result (and any write-back) follows in the execute state once the output
// register is free, so one item is worked on at a time. Fill sweeps the
// store one byte a cycle through the single write port over all STORE_SIZE
// bytes (1024 with 8 pages of 128 bytes). After reset the same sweep clears
// the store to zero, and no item is accepted until it ends. Each result sits
// in an output register; a new item is accepted while it waits, and the
// block holds the following result until that register is free.
// Depends on fbbw_pkg, fbbw_in_if, fbbw_out_if, fbbw_store, fbbw_ctrl.
module framebuffer_blend_writer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fbbw_in_if.sink     i_cmd,
    fbbw_out_if.source  o_res
);
    import fbbw_pkg::*;

    t_mem_req          mem_req;
    logic [BYTE_W-1:0] mem_rdata;

    fbbw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (i_cmd),
        .o_res       (o_res),
        .o_mem_req   (mem_req),
        .i_mem_rdata (mem_rdata)
    );

    fbbw_store u_store (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

endmodule

FILE: dv/fbbw_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the framebuffer blend writer: watches the command and result
// channels, predicts each reply from its own store and cursor, and compares.
// Depends on fbbw_pkg, fbbw_in_if, fbbw_out_if.
module fbbw_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    fbbw_in_if   i_cmd,
    fbbw_out_if  i_res,
    input  logic i_wrap_up,
    output int   o_fail_count,
    output int   o_backlog
);
    import fbbw_pkg::*;

    typedef struct packed {
        logic [BYTE_W-1:0]   read_data;
        logic [CURSOR_W-1:0] cursor;
        logic                done_res;
    } t_fb_reply;

    logic [BYTE_W-1:0]   pixels [STORE_SIZE];
    logic [CURSOR_W-1:0] draw_cursor;
    t_fb_reply           queued_replies [$];
    int                  fail_total = 0;
    int                  reply_count = 0;
    bit                  wrapped = 1'b0;

    assign o_fail_count = fail_total;

    task automatic report_mismatch(input string what);
        $display("[%0t] %s", $time, what);
        fail_total++;
    endtask

    // blend one byte in at the cursor and advance; nothing past the end
    function automatic logic blend_at_cursor(input logic [BYTE_W-1:0] px,
                                             input logic [BLEND_W-1:0] mode);
        logic [BYTE_W-1:0] old;
        if (draw_cursor >= STORE_SIZE) return 1'b0;
        old = pixels[draw_cursor];
        case (mode)
            BLEND_REPLACE: pixels[draw_cursor] = px;
            BLEND_OR:      pixels[draw_cursor] = old | px;
            BLEND_AND_NOT: pixels[draw_cursor] = old & ~px;
            default:       pixels[draw_cursor] = old ^ px;
        endcase
        draw_cursor = draw_cursor + 1'b1;
        return 1'b1;
    endfunction

    function automatic t_fb_reply run_command(input logic [CMD_W-1:0]   op,
                                              input logic [POS_W-1:0]   pg,
                                              input logic [POS_W-1:0]   col,
                                              input logic [BYTE_W-1:0]  px,
                                              input logic [BLEND_W-1:0] bl,
                                              input logic               fls);
        t_fb_reply   r;
        int unsigned addr;
        int unsigned line_start;
        r = '0;
        addr = int'(pg) * PAGE_WIDTH + int'(col);
        case (op)
            CMD_SET_POS: begin
                if (addr < STORE_SIZE) begin
                    draw_cursor = CURSOR_W'(addr);
                    r.done_res = 1'b1;
                end
            end
            CMD_WRITE: r.done_res = blend_at_cursor(px, bl);
            CMD_FIXED_WRITE: begin
                // skip when the next byte would wrap into the following page
                if (int'(draw_cursor) / PAGE_WIDTH == (int'(draw_cursor) + 1) / PAGE_WIDTH)
                    r.done_res = blend_at_cursor(px, bl);
            end
            CMD_NEXT_LINE: begin
                if (fls) line_start = (int'(draw_cursor) / PAGE_WIDTH + 1) * PAGE_WIDTH;
                else     line_start = int'(draw_cursor) + PAGE_WIDTH;
                if (line_start < STORE_SIZE) begin
                    draw_cursor = CURSOR_W'(line_start);
                    r.done_res = 1'b1;
                end
            end
            CMD_FILL: begin
                foreach (pixels[k]) pixels[k] = px;
                r.done_res = 1'b1;
            end
            CMD_READ: begin
                if (addr < STORE_SIZE) begin
                    r.read_data = pixels[addr];
                    r.done_res = 1'b1;
                end
            end
            default: ;
        endcase
        r.cursor = draw_cursor;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_fb_reply want;
        if (!i_rst_n) begin
            foreach (pixels[k]) pixels[k] = '0;
            draw_cursor = '0;
            queued_replies.delete();
        end else begin
            // take the command first so a reply in the same edge finds it
            if (i_cmd.valid && i_cmd.ready) begin
                queued_replies.push_back(run_command(i_cmd.command, i_cmd.page,
                    i_cmd.column, i_cmd.pixel_byte, i_cmd.blend, i_cmd.from_line_start));
            end
            if (i_res.valid && i_res.ready) begin
                reply_count++;
                if (queued_replies.size() == 0) begin
                    report_mismatch($sformatf("reply %0d arrived with no command outstanding",
                                              reply_count));
                end else begin
                    want = queued_replies.pop_front();
                    if (i_res.read_data !== want.read_data)
                        report_mismatch($sformatf("reply %0d read_data %h, want %h",
                                                  reply_count, i_res.read_data, want.read_data));
                    if (i_res.cursor !== want.cursor)
                        report_mismatch($sformatf("reply %0d cursor %0d, want %0d",
                                                  reply_count, i_res.cursor, want.cursor));
                    if (i_res.done_res !== want.done_res)
                        report_mismatch($sformatf("reply %0d done_res %b, want %b",
                                                  reply_count, i_res.done_res, want.done_res));
                end
            end
            if (i_wrap_up && !wrapped) begin
                wrapped = 1'b1;
                if (queued_replies.size() != 0)
                    report_mismatch($sformatf("%0d replies never arrived",
                                              queued_replies.size()));
            end
        end
        o_backlog = queued_replies.size();
    end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// Top of the framebuffer blend writer testbench: clock, reset, command and
// reply drivers, watchdog and verdict. Depends on fbbw_pkg, the channel
// interfaces, framebuffer_blend_writer_top and fbbw_checker.
module testbench;
    import fbbw_pkg::*;

    localparam int ITEM_TOTAL      = 1050;
    localparam int STALL_LIMIT     = 6000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int QUIET_ITEMS     = 200;
    localparam int PRESSURE_AT     = 600;
    localparam int DRAIN_CYCLES    = 64;

    // codes the block leaves unused
    localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic wrap_up;
    int   fail_count;
    int   backlog;
    bit   idle_on = 1'b1;
    bit   hold_req = 1'b0;
    int   sent = 0;
    int   quiet_cycles = 0;

    fbbw_in_if  cmd_ch ();
    fbbw_out_if res_ch ();

    always #6 i_clk = ~i_clk;

    framebuffer_blend_writer_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch)
    );

    fbbw_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd_ch),
        .i_res        (res_ch),
        .i_wrap_up    (wrap_up),
        .o_fail_count (fail_count),
        .o_backlog    (backlog)
    );

    // abort when neither channel moves for too long
    always @(posedge i_clk) begin
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // reply side: random stalls, plus one long hold-off on request
    initial begin
        int hold_left;
        bit hold_taken;
        hold_left = 0;
        hold_taken = 1'b0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= !(idle_on && $urandom_range(99) < 30);
            end
        end
    end

    task automatic push_cmd(input logic [CMD_W-1:0]   op,
                            input logic [POS_W-1:0]   pg,
                            input logic [POS_W-1:0]   col,
                            input logic [BYTE_W-1:0]  px,
                            input logic [BLEND_W-1:0] bl,
                            input logic               fls);
        while (idle_on && $urandom_range(99) < 30) begin
            cmd_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_ch.valid           <= 1'b1;
        cmd_ch.command         <= op;
        cmd_ch.page            <= pg;
        cmd_ch.column          <= col;
        cmd_ch.pixel_byte      <= px;
        cmd_ch.blend           <= bl;
        cmd_ch.from_line_start <= fls;
        do @(posedge i_clk); while (!cmd_ch.ready);
        if (op <= CMD_READ) sent++;
    endtask

    task automatic push_at(input logic [CMD_W-1:0] op, input int pg, input int col);
        push_cmd(op, POS_W'(pg), POS_W'(col), BYTE_W'($urandom_range(255)),
                 BLEND_W'($urandom_range(3)), 1'($urandom_range(1)));
    endtask

    task automatic push_rand(input logic [CMD_W-1:0] op);
        push_at(op, $urandom_range(255), $urandom_range(255));
    endtask

    initial begin
        int pick;
        int n;
        int quiet_until;
        bit pressure_done;
        pressure_done = 1'b0;
        quiet_until = 0;
        i_rst_n                <= 1'b0;
        wrap_up                <= 1'b0;
        cmd_ch.valid           <= 1'b0;
        cmd_ch.command         <= '0;
        cmd_ch.page            <= '0;
        cmd_ch.column          <= '0;
        cmd_ch.pixel_byte      <= '0;
        cmd_ch.blend           <= '0;
        cmd_ch.from_line_start <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: blends, wraps, the end of the store, fill, spare codes
        push_at(CMD_READ, 0, 0);
        push_cmd(CMD_WRITE, 0, 0, 8'hFF, BLEND_REPLACE, 1'b0);
        push_cmd(CMD_WRITE, 0, 0, 8'hA5, BLEND_OR, 1'b0);
        push_at(CMD_SET_POS, 0, 0);
        push_cmd(CMD_WRITE, 0, 0, 8'h0F, BLEND_AND_NOT, 1'b0);
        push_cmd(CMD_FIXED_WRITE, 0, 0, 8'hFF, BLEND_XOR, 1'b0);
        push_at(CMD_READ, 0, 1);
        push_at(CMD_SET_POS, 0, 255);
        push_cmd(CMD_NEXT_LINE, 0, 0, 8'h00, BLEND_REPLACE, 1'b1);
        push_at(CMD_SET_POS, 6, 5);
        push_cmd(CMD_NEXT_LINE, 0, 0, 8'h00, BLEND_REPLACE, 1'b0);
        push_cmd(CMD_NEXT_LINE, 0, 0, 8'h00, BLEND_REPLACE, 1'b0);
        push_at(CMD_SET_POS, PAGE_COUNT - 1, PAGE_WIDTH - 1);
        push_cmd(CMD_FIXED_WRITE, 0, 0, 8'h55, BLEND_REPLACE, 1'b0);
        push_cmd(CMD_WRITE, 0, 0, 8'h81, BLEND_XOR, 1'b0);
        push_cmd(CMD_WRITE, 0, 0, 8'h7E, BLEND_REPLACE, 1'b0);
        push_cmd(CMD_FIXED_WRITE, 0, 0, 8'h7E, BLEND_OR, 1'b0);
        push_cmd(CMD_NEXT_LINE, 0, 0, 8'h00, BLEND_REPLACE, 1'b1);
        push_at(CMD_SET_POS, PAGE_COUNT, 0);
        push_at(CMD_SET_POS, 255, 255);
        push_at(CMD_READ, PAGE_COUNT - 1, PAGE_WIDTH - 1);
        push_at(CMD_READ, 255, 255);
        push_cmd(CMD_FILL, 0, 0, 8'h3C, BLEND_REPLACE, 1'b0);
        push_at(CMD_READ, 3, 3);
        push_rand(CMD_SPARE_6);
        push_rand(CMD_SPARE_7);

        // random drawing sessions
        while (sent < ITEM_TOTAL) begin
            if (!pressure_done && sent >= PRESSURE_AT) begin
                pressure_done = 1'b1;
                idle_on = 1'b0;
                hold_req = 1'b1;
                quiet_until = sent + QUIET_ITEMS;
            end
            if (!idle_on && sent >= quiet_until) idle_on = 1'b1;
            pick = $urandom_range(99);
            if (pick < 40) begin
                push_at(CMD_SET_POS, $urandom_range(PAGE_COUNT - 1),
                        $urandom_range(PAGE_WIDTH - 1));
                n = $urandom_range(12, 1);
                repeat (n)
                    push_rand(($urandom_range(3) == 0) ? CMD_FIXED_WRITE : CMD_WRITE);
                if ($urandom_range(3) == 0) push_rand(CMD_NEXT_LINE);
            end else if (pick < 60) begin
                // hug the end of a page so fixed-line writes get skipped
                push_at(CMD_SET_POS, $urandom_range(PAGE_COUNT - 1),
                        PAGE_WIDTH - 1 - $urandom_range(2));
                n = $urandom_range(5, 1);
                repeat (n)
                    push_rand($urandom_range(1) ? CMD_FIXED_WRITE : CMD_WRITE);
            end else if (pick < 80) begin
                n = $urandom_range(6, 1);
                repeat (n)
                    push_at(CMD_READ, $urandom_range(PAGE_COUNT - 1),
                            ($urandom_range(4) == 0) ? $urandom_range(255)
                                                     : $urandom_range(PAGE_WIDTH - 1));
            end else if (pick < 90) begin
                n = $urandom_range(3, 1);
                repeat (n) push_rand(CMD_NEXT_LINE);
            end else if (pick < 92) begin
                push_rand(CMD_FILL);
            end else if (pick < 96) begin
                // run off the end of the store
                push_at(CMD_SET_POS, PAGE_COUNT - 1, PAGE_WIDTH - 1 - $urandom_range(3));
                n = $urandom_range(6, 2);
                repeat (n)
                    push_rand($urandom_range(1) ? CMD_FIXED_WRITE : CMD_WRITE);
                if ($urandom_range(1)) push_rand(CMD_NEXT_LINE);
            end else begin
                push_rand(CMD_W'($urandom_range(7)));
            end
        end
        cmd_ch.valid <= 1'b0;

        n = 0;
        while (backlog != 0 && n < STALL_LIMIT) begin
            @(posedge i_clk);
            n++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        wrap_up <= 1'b1;
        repeat (3) @(posedge i_clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: framebuffer_blend_writer_top.f
rtl/fbbw_pkg.sv
rtl/fbbw_in_if.sv
rtl/fbbw_out_if.sv
rtl/fbbw_store.sv
rtl/fbbw_ctrl.sv
rtl/framebuffer_blend_writer_top.sv
dv/fbbw_checker.sv
dv/testbench.sv
